// File: hw/rtl/usbfs_pkg.sv
package usbfs_pkg;

  localparam int PMEM_BYTES_DEF      = 2048;
  localparam int REG_SPACE_BYTES_DEF = 1024;
  localparam int NUM_ENDPOINTS_DEF   = 8;

  localparam logic [2:0] CMD_REG_RD  = 3'd0;
  localparam logic [2:0] CMD_REG_WR  = 3'd1;
  localparam logic [2:0] CMD_PMEM_RD = 3'd2;
  localparam logic [2:0] CMD_PMEM_WR = 3'd3;
  localparam logic [2:0] CMD_OUT     = 3'd4;
  localparam logic [2:0] CMD_IN      = 3'd5;
  localparam logic [2:0] CMD_BUS_RST = 3'd6;
  localparam logic [2:0] CMD_RSVD    = 3'd7;

  localparam logic [7:0] IDX_CNTR   = 8'h10;
  localparam logic [7:0] IDX_ISTR   = 8'h11;
  localparam logic [7:0] IDX_DADDR  = 8'h13;
  localparam logic [7:0] IDX_BTABLE = 8'h14;

  localparam logic [15:0] EP_CTR_RX = 16'h8000;
  localparam logic [15:0] EP_SETUP  = 16'h0800;
  localparam logic [15:0] EP_FIXED  = 16'h070F;
  localparam logic [15:0] EP_CTR_TX = 16'h0080;
  localparam logic [15:0] EP_TOGGLE = 16'h7070;

  localparam logic [1:0] STAT_NAK   = 2'd2;
  localparam logic [1:0] STAT_VALID = 2'd3;

  localparam logic [31:0] ISTR_CTR   = 32'h0000_8000;
  localparam logic [31:0] ISTR_RESET = 32'h0000_0400;
  localparam logic [31:0] ISTR_DIR   = 32'h0000_0010;
  localparam logic [31:0] DESC_CNT   = 32'h03FF_0000;

  typedef enum logic {
    ST_IDLE,
    ST_WB
  } state_t;

endpackage

// File: hw/rtl/usbfs_ram.sv
module usbfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/usbfs_pmem.sv
module usbfs_pmem #(
  parameter int PMEM_BYTES = usbfs_pkg::PMEM_BYTES_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic [3:0][$clog2(PMEM_BYTES/4)-1:0]     rd_row,
  input  logic [3:0]                               wr_en,
  input  logic [3:0][$clog2(PMEM_BYTES/4)-1:0]     wr_row,
  input  logic [3:0][7:0]                          wr_data,
  output logic [3:0][7:0]                          rd_data,
  output logic                                     clr_busy
);

  localparam int ROWS = PMEM_BYTES / 4;
  localparam int RW   = $clog2(ROWS);

  logic          clr_r, clr_nxt;
  logic [RW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    clr_nxt = clr_r;
    cnt_nxt = cnt_r;
    if (clr_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == RW'(ROWS - 1)) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= 1'b1;
      cnt_r <= '0;
    end else begin
      clr_r <= clr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign clr_busy = clr_r;

  for (genvar k = 0; k < 4; k++) begin : g_lane
    usbfs_ram #(.WIDTH(8), .DEPTH(ROWS)) u_lane (
      .clk  (clk),
      .we   (clr_r | wr_en[k]),
      .waddr(clr_r ? cnt_r : wr_row[k]),
      .wdata(clr_r ? 8'h00 : wr_data[k]),
      .raddr(rd_row[k]),
      .rdata(rd_data[k])
    );
  end

endmodule

// File: hw/rtl/usb_fs_device_endpoint_controller_core.sv
// USB full-speed device controller core with packet memory.
// Input channel: the command and its fields on in_* are taken at a rising
// edge with start high and busy low. Commands: register read/write, packet
// memory read/write, host OUT completion, host IN request, bus reset.
// Result channel: one result per command on out_*, marked by out_valid for
// exactly one cycle; out_valid and out_* are registered from the write-back state.
// Commands do not overlap: the next is taken after write-back. The accept cycle issues the
// reads of the general register RAM and the four packet memory byte lanes;
// the next cycle modifies and writes back, so busy is high for one cycle.
// Packet memory is four byte-lane RAMs; an unaligned access of up to four
// bytes touches one row in each lane.
// Reset: endpoint registers, CNTR/ISTR/DADDR/BTABLE and the register RAM
// valid bits clear at once; packet memory is then swept to zero one row a
// cycle over all PMEM_BYTES/4 rows, with busy held high.
// The receiver cannot stall: each result must be taken in its cycle.
module usb_fs_device_endpoint_controller_core #(
  parameter int PMEM_BYTES      = usbfs_pkg::PMEM_BYTES_DEF,
  parameter int REG_SPACE_BYTES = usbfs_pkg::REG_SPACE_BYTES_DEF,
  parameter int NUM_ENDPOINTS   = usbfs_pkg::NUM_ENDPOINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [10:0] in_address,
  input  logic [2:0]  in_access_size,
  input  logic [31:0] in_write_data,
  input  logic [2:0]  in_endpoint,
  input  logic        in_setup_packet,
  input  logic [9:0]  in_length,
  input  logic [9:0]  in_max_length,
  output logic        out_valid,
  output logic        out_ok,
  output logic [31:0] out_read_data,
  output logic        out_irq,
  output logic [15:0] out_buffer_addr,
  output logic [9:0]  out_xfer_length
);

  localparam int RW  = $clog2(PMEM_BYTES / 4);
  localparam int EPW = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;

  usbfs_pkg::state_t state_r, state_nxt;
  logic acc, wb, clr_busy;

  logic [2:0]  cmd_r;
  logic [10:0] addr_r;
  logic [2:0]  size_r;
  logic [31:0] wdata_r;
  logic [2:0]  epn_r;
  logic        setup_r;
  logic [9:0]  len_r;
  logic [9:0]  maxl_r;
  logic        dok_r;
  logic [3:0][RW-1:0] row_r;

  logic [15:0] eps_r [NUM_ENDPOINTS];
  logic [15:0] eps_nxt [NUM_ENDPOINTS];
  logic [31:0] cntr_r, istr_r, daddr_r, btable_r;
  logic [31:0] cntr_nxt, istr_nxt, daddr_nxt, btable_nxt;
  logic [255:0] gval_r, gval_nxt;

  logic        out_valid_r, out_ok_r, out_irq_r;
  logic [31:0] out_rd_r;
  logic [15:0] out_ba_r;
  logic [9:0]  out_xl_r;
  logic        ok_c, irq_c;
  logic [31:0] rd_c;
  logic [15:0] ba_c;
  logic [9:0]  xl_c;

  logic [16:0] dsc;
  logic        dok;
  logic [3:0][RW-1:0] row_c;
  logic [31:0] gq;
  logic        g_we;
  logic [31:0] g_wd;
  logic [3:0][7:0] pq;
  logic [3:0]      p_we;
  logic [3:0][7:0] p_wd;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      usbfs_pkg::ST_IDLE: if (acc) state_nxt = usbfs_pkg::ST_WB;
      usbfs_pkg::ST_WB:   state_nxt = usbfs_pkg::ST_IDLE;
      default:            state_nxt = usbfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_r != usbfs_pkg::ST_IDLE) | clr_busy;
    wb   = (state_r == usbfs_pkg::ST_WB);
  end

  assign acc = start & ~busy;

  always_comb begin
    logic [1:0]  ik;
    logic [11:0] ba;
    dsc = {1'b0, btable_r[15:3], 3'b000} + {11'b0, in_endpoint, 3'b000}
        + ((in_command == usbfs_pkg::CMD_OUT) ? 17'd4 : 17'd0);
    dok = ({15'b0, dsc} + 32'd4) <= 32'(PMEM_BYTES);
    for (int k = 0; k < 4; k++) begin
      ik = 2'(k) - in_address[1:0];
      ba = {1'b0, in_address} + {10'b0, ik};
      if (in_command == usbfs_pkg::CMD_OUT || in_command == usbfs_pkg::CMD_IN) begin
        row_c[k] = dsc[RW+1:2];
      end else begin
        row_c[k] = ba[RW+1:2];
      end
    end
  end

  usbfs_ram #(.WIDTH(32), .DEPTH(256)) u_greg (
    .clk  (clk),
    .we   (g_we),
    .waddr(addr_r[9:2]),
    .wdata(g_wd),
    .raddr(in_address[9:2]),
    .rdata(gq)
  );

  usbfs_pmem #(.PMEM_BYTES(PMEM_BYTES)) u_pmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_row  (row_c),
    .wr_en   (p_we),
    .wr_row  (row_r),
    .wr_data (p_wd),
    .rd_data (pq),
    .clr_busy(clr_busy)
  );

  always_comb begin
    logic        size_ok, aligned, pm_ok, ep_ex, any, stat_ok;
    logic [7:0]  idx;
    logic [31:0] cur, w, nv, iv;
    logic [15:0] v, er;
    logic [EPW-1:0] ea;
    logic [1:0]  ik;
    logic [9:0]  cnt;

    for (int i = 0; i < NUM_ENDPOINTS; i++) eps_nxt[i] = eps_r[i];
    cntr_nxt = cntr_r;
    istr_nxt = istr_r;
    daddr_nxt = daddr_r;
    btable_nxt = btable_r;
    gval_nxt = gval_r;
    g_we = 1'b0;
    g_wd = '0;
    p_we = '0;
    p_wd = '0;
    ok_c = 1'b0;
    irq_c = 1'b0;
    rd_c = '0;
    ba_c = '0;
    xl_c = '0;

    size_ok = (size_r >= 3'd1) && (size_r <= 3'd4);
    aligned = (addr_r[1:0] == 2'b00);
    pm_ok = size_ok && (({21'b0, addr_r} + {29'b0, size_r}) <= 32'(PMEM_BYTES));
    idx = addr_r[9:2];
    case (idx)
      usbfs_pkg::IDX_CNTR:   cur = cntr_r;
      usbfs_pkg::IDX_ISTR:   cur = istr_r;
      usbfs_pkg::IDX_DADDR:  cur = daddr_r;
      usbfs_pkg::IDX_BTABLE: cur = btable_r;
      default:               cur = gval_r[idx] ? gq : 32'h0;
    endcase
    w = dok_r ? {pq[3], pq[2], pq[1], pq[0]} : 32'h0;
    v = wdata_r[15:0];
    ea = '0;
    ep_ex = 1'b0;
    er = '0;
    any = 1'b0;
    stat_ok = 1'b0;
    nv = '0;
    iv = istr_r;
    cnt = '0;

    if (cmd_r == usbfs_pkg::CMD_REG_RD || cmd_r == usbfs_pkg::CMD_REG_WR) begin
      ea = addr_r[EPW+1:2];
      ep_ex = (int'(addr_r[4:2]) < NUM_ENDPOINTS);
    end else begin
      ea = epn_r[EPW-1:0];
      ep_ex = (int'(epn_r) < NUM_ENDPOINTS);
    end
    if (ep_ex) er = eps_r[ea];

    if (wb) begin
      case (cmd_r)
        usbfs_pkg::CMD_REG_RD: begin
          if (size_ok && aligned) begin
            if (addr_r < 11'h20) begin
              rd_c = {16'h0, er};
              ok_c = 1'b1;
            end else if (32'(addr_r) < 32'(REG_SPACE_BYTES)) begin
              rd_c = cur;
              ok_c = 1'b1;
            end
            if (size_r == 3'd2) rd_c = rd_c & 32'h0000_FFFF;
          end
        end
        usbfs_pkg::CMD_REG_WR: begin
          if (size_ok && aligned) begin
            if (addr_r < 11'h20) begin
              ok_c = 1'b1;
              if (ep_ex) begin
                if (!v[15]) er = er & ~(usbfs_pkg::EP_CTR_RX | usbfs_pkg::EP_SETUP);
                if (!v[7]) er = er & ~usbfs_pkg::EP_CTR_TX;
                er = er ^ (v & usbfs_pkg::EP_TOGGLE);
                er = (er & ~usbfs_pkg::EP_FIXED) | (v & usbfs_pkg::EP_FIXED);
                eps_nxt[ea] = er;
                for (int i = 0; i < NUM_ENDPOINTS; i++) begin
                  if ((eps_nxt[i] & (usbfs_pkg::EP_CTR_RX | usbfs_pkg::EP_CTR_TX)) != 16'h0)
                    any = 1'b1;
                end
                if (!any) istr_nxt = istr_r & ~usbfs_pkg::ISTR_CTR;
              end
            end else if (32'(addr_r) < 32'(REG_SPACE_BYTES)) begin
              ok_c = 1'b1;
              if (size_r == 3'd2) begin
                nv = {16'h0, wdata_r[15:0]};
                if (idx == usbfs_pkg::IDX_ISTR) nv = nv & cur;
                nv = (cur & 32'hFFFF_0000) | nv;
              end else if (idx == usbfs_pkg::IDX_ISTR) begin
                nv = cur & wdata_r;
              end else begin
                nv = wdata_r;
              end
              case (idx)
                usbfs_pkg::IDX_CNTR:   cntr_nxt = nv;
                usbfs_pkg::IDX_ISTR:   istr_nxt = nv;
                usbfs_pkg::IDX_DADDR:  daddr_nxt = nv;
                usbfs_pkg::IDX_BTABLE: btable_nxt = nv;
                default: begin
                  g_we = 1'b1;
                  g_wd = nv;
                  gval_nxt[idx] = 1'b1;
                end
              endcase
            end
          end
        end
        usbfs_pkg::CMD_PMEM_RD: begin
          if (pm_ok) begin
            ok_c = 1'b1;
            for (int i = 0; i < 4; i++) begin
              ik = addr_r[1:0] + 2'(i);
              if (3'(i) < size_r) rd_c[8*i +: 8] = pq[ik];
            end
          end
        end
        usbfs_pkg::CMD_PMEM_WR: begin
          if (pm_ok) begin
            ok_c = 1'b1;
            for (int k = 0; k < 4; k++) begin
              ik = 2'(k) - addr_r[1:0];
              p_we[k] = ({1'b0, ik} < size_r);
              p_wd[k] = wdata_r[8*ik +: 8];
            end
          end
        end
        usbfs_pkg::CMD_OUT, usbfs_pkg::CMD_IN: begin
          if (cmd_r == usbfs_pkg::CMD_OUT) begin
            stat_ok = (er[13:12] == usbfs_pkg::STAT_VALID) || (setup_r && epn_r == 3'd0);
          end else begin
            stat_ok = (er[5:4] == usbfs_pkg::STAT_VALID);
          end
          if (ep_ex && daddr_r[7] && stat_ok) begin
            ok_c = 1'b1;
            ba_c = {w[15:2], 2'b00};
            iv = istr_r | usbfs_pkg::ISTR_CTR;
            iv[3:0] = {1'b0, epn_r};
            if (cmd_r == usbfs_pkg::CMD_OUT) begin
              nv = (w & ~usbfs_pkg::DESC_CNT) | {6'h0, len_r, 16'h0};
              p_we = {4{dok_r}};
              p_wd = nv;
              er = er | usbfs_pkg::EP_CTR_RX;
              if (setup_r) er = er | usbfs_pkg::EP_SETUP;
              er[13:12] = usbfs_pkg::STAT_NAK;
              iv = iv | usbfs_pkg::ISTR_DIR;
            end else begin
              cnt = w[25:16];
              xl_c = (cnt > maxl_r) ? maxl_r : cnt;
              er = er | usbfs_pkg::EP_CTR_TX;
              er[5:4] = usbfs_pkg::STAT_NAK;
              iv = iv & ~usbfs_pkg::ISTR_DIR;
            end
            eps_nxt[ea] = er;
            istr_nxt = iv;
            irq_c = cntr_r[15];
          end
        end
        usbfs_pkg::CMD_BUS_RST: begin
          istr_nxt = istr_r | usbfs_pkg::ISTR_RESET;
          irq_c = cntr_r[15];
          ok_c = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= usbfs_pkg::ST_IDLE;
      for (int i = 0; i < NUM_ENDPOINTS; i++) eps_r[i] <= '0;
      cntr_r <= '0;
      istr_r <= '0;
      daddr_r <= '0;
      btable_r <= '0;
      gval_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= wb;
      if (wb) begin
        for (int i = 0; i < NUM_ENDPOINTS; i++) eps_r[i] <= eps_nxt[i];
        cntr_r <= cntr_nxt;
        istr_r <= istr_nxt;
        daddr_r <= daddr_nxt;
        btable_r <= btable_nxt;
        gval_r <= gval_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_r <= in_command;
      addr_r <= in_address;
      size_r <= in_access_size;
      wdata_r <= in_write_data;
      epn_r <= in_endpoint;
      setup_r <= in_setup_packet;
      len_r <= in_length;
      maxl_r <= in_max_length;
      dok_r <= dok;
      row_r <= row_c;
    end
    if (wb) begin
      out_ok_r <= ok_c;
      out_rd_r <= rd_c;
      out_irq_r <= irq_c;
      out_ba_r <= ba_c;
      out_xl_r <= xl_c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_ok = out_ok_r;
  assign out_read_data = out_rd_r;
  assign out_irq = out_irq_r;
  assign out_buffer_addr = out_ba_r;
  assign out_xfer_length = out_xl_r;

  a_accept_wb: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (state_r == usbfs_pkg::ST_WB))
    else $error("accepted command did not enter write-back");

  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(out_valid))
    else $error("result strobe held longer than one cycle");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_read_data == 32'h0 && !out_irq
      && out_buffer_addr == 16'h0 && out_xfer_length == 10'h0))
    else $error("rejected command carries nonzero result");

  a_busy_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> busy)
    else $error("accepting while packet memory is clearing");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int PMEM  = usbfs_pkg::PMEM_BYTES_DEF;
  localparam int REGSP = usbfs_pkg::REG_SPACE_BYTES_DEF;
  localparam int NEP   = usbfs_pkg::NUM_ENDPOINTS_DEF;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  command;
    logic [10:0] address;
    logic [2:0]  access_size;
    logic [31:0] write_data;
    logic [2:0]  endpoint;
    logic        setup_packet;
    logic [9:0]  length;
    logic [9:0]  max_length;
  } usb_cmd_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] read_data;
    logic        irq;
    logic [15:0] buffer_addr;
    logic [9:0]  xfer_length;
  } usb_resp_t;

  localparam int CMD_W = $bits(usb_cmd_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_command = '0;
  logic [10:0] in_address = '0;
  logic [2:0] in_access_size = '0;
  logic [31:0] in_write_data = '0;
  logic [2:0] in_endpoint = '0;
  logic in_setup_packet = 1'b0;
  logic [9:0] in_length = '0;
  logic [9:0] in_max_length = '0;
  logic out_valid, out_ok, out_irq;
  logic [31:0] out_read_data;
  logic [15:0] out_buffer_addr;
  logic [9:0] out_xfer_length;

  usb_fs_device_endpoint_controller_core i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_address(in_address),
    .in_access_size(in_access_size), .in_write_data(in_write_data),
    .in_endpoint(in_endpoint), .in_setup_packet(in_setup_packet),
    .in_length(in_length), .in_max_length(in_max_length),
    .out_valid(out_valid), .out_ok(out_ok), .out_read_data(out_read_data),
    .out_irq(out_irq), .out_buffer_addr(out_buffer_addr),
    .out_xfer_length(out_xfer_length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  logic [15:0] ep_reg [NEP];
  logic [31:0] gen_reg [256];
  logic [7:0]  pmem [PMEM];

  usb_cmd_t  cmd_q [$];
  usb_resp_t resp_q [$];
  int errors = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;

  function automatic logic [31:0] desc_rd(int unsigned a);
    if (a + 3 >= PMEM) return '0;
    return {pmem[a+3], pmem[a+2], pmem[a+1], pmem[a]};
  endfunction

  function automatic logic flag_xfer(logic [2:0] ep, logic dir_out);
    logic [31:0] s;
    s = gen_reg[usbfs_pkg::IDX_ISTR] | usbfs_pkg::ISTR_CTR;
    s = {s[31:4], 1'b0, ep};
    s = dir_out ? (s | usbfs_pkg::ISTR_DIR) : (s & ~usbfs_pkg::ISTR_DIR);
    gen_reg[usbfs_pkg::IDX_ISTR] = s;
    return gen_reg[usbfs_pkg::IDX_CNTR][15];
  endfunction

  function automatic void ep_reg_update(int unsigned ep, logic [31:0] v);
    logic [15:0] r;
    bit any;
    any = 0;
    if (ep >= NEP) return;
    r = ep_reg[ep];
    if (!v[15]) r &= ~(usbfs_pkg::EP_CTR_RX | usbfs_pkg::EP_SETUP);
    if (!v[7]) r &= ~usbfs_pkg::EP_CTR_TX;
    r ^= v[15:0] & usbfs_pkg::EP_TOGGLE;
    r = (r & ~usbfs_pkg::EP_FIXED) | (v[15:0] & usbfs_pkg::EP_FIXED);
    ep_reg[ep] = r;
    for (int i = 0; i < NEP; i++)
      if (ep_reg[i] & (usbfs_pkg::EP_CTR_RX | usbfs_pkg::EP_CTR_TX)) any = 1;
    if (!any) gen_reg[usbfs_pkg::IDX_ISTR] &= ~usbfs_pkg::ISTR_CTR;
  endfunction

  function automatic usb_resp_t controller_predict(usb_cmd_t c);
    usb_resp_t r;
    bit size_ok, aligned;
    int unsigned a, sz, d;
    logic [7:0] idx;
    logic [31:0] cur, lo, wd, w;
    logic [15:0] reg16;
    r = '0;
    a = c.address;
    sz = c.access_size;
    size_ok = sz >= 1 && sz <= 4;
    aligned = a[1:0] == 0;
    idx = a[9:2];
    case (c.command)
      usbfs_pkg::CMD_REG_RD: if (size_ok && aligned && a < REGSP) begin
        if (a < 32) r.read_data = (a / 4 < NEP) ? 32'(ep_reg[a/4]) : '0;
        else r.read_data = gen_reg[idx];
        if (sz == 2) r.read_data &= 32'hFFFF;
        r.ok = 1;
      end
      usbfs_pkg::CMD_REG_WR: if (size_ok && aligned && a < REGSP) begin
        wd = c.write_data;
        if (a < 32) begin
          if (sz == 2) wd &= 32'hFFFF;
          ep_reg_update(a / 4, wd);
        end else begin
          cur = gen_reg[idx];
          if (sz == 2) begin
            lo = wd & 32'hFFFF;
            if (idx == usbfs_pkg::IDX_ISTR) lo &= cur;
            gen_reg[idx] = (cur & 32'hFFFF0000) | lo;
          end else if (idx == usbfs_pkg::IDX_ISTR) gen_reg[idx] = cur & wd;
          else gen_reg[idx] = wd;
        end
        r.ok = 1;
      end
      usbfs_pkg::CMD_PMEM_RD: if (size_ok && a + sz <= PMEM) begin
        for (int i = 0; i < sz; i++) r.read_data |= 32'(pmem[a+i]) << (8 * i);
        r.ok = 1;
      end
      usbfs_pkg::CMD_PMEM_WR: if (size_ok && a + sz <= PMEM) begin
        for (int i = 0; i < sz; i++) pmem[a+i] = c.write_data[8*i +: 8];
        r.ok = 1;
      end
      usbfs_pkg::CMD_OUT: if (c.endpoint < NEP && gen_reg[usbfs_pkg::IDX_DADDR][7]) begin
        reg16 = ep_reg[c.endpoint];
        if (reg16[13:12] == usbfs_pkg::STAT_VALID || (c.setup_packet && c.endpoint == 0)) begin
          d = (gen_reg[usbfs_pkg::IDX_BTABLE] & 32'hFFF8) + 8 * c.endpoint + 4;
          w = desc_rd(d);
          r.buffer_addr = w[15:0] & 16'hFFFC;
          w = (w & ~usbfs_pkg::DESC_CNT) | (32'(c.length) << 16);
          if (d + 3 < PMEM) for (int i = 0; i < 4; i++) pmem[d+i] = w[8*i +: 8];
          reg16 |= usbfs_pkg::EP_CTR_RX;
          if (c.setup_packet) reg16 |= usbfs_pkg::EP_SETUP;
          reg16[13:12] = usbfs_pkg::STAT_NAK;
          ep_reg[c.endpoint] = reg16;
          r.irq = flag_xfer(c.endpoint, 1'b1);
          r.ok = 1;
        end
      end
      usbfs_pkg::CMD_IN: if (c.endpoint < NEP && gen_reg[usbfs_pkg::IDX_DADDR][7]) begin
        reg16 = ep_reg[c.endpoint];
        if (reg16[5:4] == usbfs_pkg::STAT_VALID) begin
          w = desc_rd((gen_reg[usbfs_pkg::IDX_BTABLE] & 32'hFFF8) + 8 * c.endpoint);
          r.buffer_addr = w[15:0] & 16'hFFFC;
          r.xfer_length = (w[25:16] > c.max_length) ? c.max_length : w[25:16];
          reg16 |= usbfs_pkg::EP_CTR_TX;
          reg16[5:4] = usbfs_pkg::STAT_NAK;
          ep_reg[c.endpoint] = reg16;
          r.irq = flag_xfer(c.endpoint, 1'b0);
          r.ok = 1;
        end
      end
      usbfs_pkg::CMD_BUS_RST: begin
        gen_reg[usbfs_pkg::IDX_ISTR] |= usbfs_pkg::ISTR_RESET;
        r.irq = gen_reg[usbfs_pkg::IDX_CNTR][15];
        r.ok = 1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp, $time);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        resp_q.push_back(controller_predict({in_command, in_address, in_access_size,
            in_write_data, in_endpoint, in_setup_packet, in_length, in_max_length}));
      end
      if (!start || !busy) begin
        if (cmd_q.size() > 0 && (no_idle || $urandom_range(99) >= 30)) begin
          usb_cmd_t c;
          c = cmd_q.pop_front();
          start <= 1'b1;
          {in_command, in_address, in_access_size, in_write_data, in_endpoint,
           in_setup_packet, in_length, in_max_length} <= c;
        end else begin
          start <= 1'b0;
          {in_command, in_address, in_access_size, in_write_data, in_endpoint,
           in_setup_packet, in_length, in_max_length}
              <= CMD_W'({$urandom(), $urandom(), $urandom()});
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      usb_resp_t e;
      if (resp_q.size() == 0) begin
        report_mismatch("unexpected transfer", '0, '0);
      end else begin
        e = resp_q.pop_front();
        if (out_ok !== e.ok) report_mismatch("ok", 32'(out_ok), 32'(e.ok));
        if (out_read_data !== e.read_data)
          report_mismatch("read_data", out_read_data, e.read_data);
        if (out_irq !== e.irq) report_mismatch("irq", 32'(out_irq), 32'(e.irq));
        if (out_buffer_addr !== e.buffer_addr)
          report_mismatch("buffer_addr", 32'(out_buffer_addr), 32'(e.buffer_addr));
        if (out_xfer_length !== e.xfer_length)
          report_mismatch("xfer_length", 32'(out_xfer_length), 32'(e.xfer_length));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("usb_fs_device_endpoint_controller_core verification failed");
      $finish;
    end
  end

  function automatic usb_cmd_t mk(logic [2:0] cmd, logic [10:0] a, logic [2:0] sz,
                                  logic [31:0] wd);
    usb_cmd_t c;
    c = CMD_W'({$urandom(), $urandom(), $urandom()});
    c.command = cmd;
    c.address = a;
    c.access_size = sz;
    c.write_data = wd;
    return c;
  endfunction

  function automatic usb_cmd_t mk_xfer(logic [2:0] cmd, logic [2:0] ep, logic setup);
    usb_cmd_t c;
    c = mk(cmd, 11'($urandom()), 3'($urandom()), $urandom());
    c.endpoint = ep;
    c.setup_packet = setup;
    c.length = 10'($urandom());
    c.max_length = ($urandom_range(3) == 0) ? 10'h3FF : 10'($urandom());
    return c;
  endfunction

  function automatic usb_cmd_t rand_item();
    int k;
    logic [2:0] ep;
    k = $urandom_range(99);
    ep = ($urandom_range(9) == 0) ? 3'($urandom()) : 3'($urandom_range(NEP - 1));
    if (k < 10) return mk(usbfs_pkg::CMD_REG_RD, 11'($urandom_range(0, 23) * 4),
                          3'($urandom_range(1, 4)), 0);
    if (k < 14) return mk(usbfs_pkg::CMD_REG_RD, 11'($urandom()), 3'($urandom()), 0);
    if (k < 22) return mk(usbfs_pkg::CMD_REG_WR, 11'($urandom_range(0, 7) * 4),
                          3'($urandom_range(1, 4)), $urandom());
    if (k < 27) return mk(usbfs_pkg::CMD_REG_WR, 11'h44, 3'($urandom_range(1, 4)), $urandom());
    if (k < 30) return mk(usbfs_pkg::CMD_REG_WR, 11'h40, 4,
                          {16'($urandom()), 1'($urandom_range(1)), 15'($urandom())});
    if (k < 32) return mk(usbfs_pkg::CMD_REG_WR, 11'h4C, 4,
                          $urandom() | ($urandom_range(4) ? 32'h80 : 0));
    if (k < 34) return mk(usbfs_pkg::CMD_REG_WR, 11'h50, 4, ($urandom_range(3) == 0) ? $urandom()
                          : $urandom_range(0, 255) * 8);
    if (k < 37) return mk(usbfs_pkg::CMD_REG_WR, 11'($urandom()), 3'($urandom()), $urandom());
    if (k < 45) return mk(usbfs_pkg::CMD_PMEM_RD, 11'($urandom()), 3'($urandom_range(0, 7)), 0);
    if (k < 55) return mk(usbfs_pkg::CMD_PMEM_WR, ($urandom_range(1)
                          ? 11'($urandom_range(0, 255) * 4) : 11'($urandom())),
                          3'($urandom_range(0, 7)), $urandom());
    if (k < 75) return mk_xfer(usbfs_pkg::CMD_OUT, ep, ($urandom_range(3) == 0));
    if (k < 93) return mk_xfer(usbfs_pkg::CMD_IN, ep, 1'($urandom()));
    if (k < 97) return mk(usbfs_pkg::CMD_BUS_RST, 11'($urandom()), 3'($urandom()), $urandom());
    return mk(usbfs_pkg::CMD_RSVD, 11'($urandom()), 3'($urandom()), $urandom());
  endfunction

  initial begin
    int n;
    usb_cmd_t c;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // directed
    cmd_q.push_back(mk(usbfs_pkg::CMD_REG_RD, 11'h000, 4, 0));
    cmd_q.push_back(mk(usbfs_pkg::CMD_REG_RD, 11'h002, 4, 0));
    cmd_q.push_back(mk(usbfs_pkg::CMD_REG_RD, 11'h7FC, 4, 0));
    cmd_q.push_back(mk(usbfs_pkg::CMD_REG_RD, 11'h040, 0, 0));
    cmd_q.push_back(mk(usbfs_pkg::CMD_REG_RD, 11'h040, 5, 0));
    cmd_q.push_back(mk(usbfs_pkg::CMD_REG_WR, 11'h040, 4, 32'hFFFF_FFFF));
    cmd_q.push_back(mk(usbfs_pkg::CMD_REG_RD, 11'h040, 2, 0));
    cmd_q.push_back(mk(usbfs_pkg::CMD_REG_WR, 11'h050, 4, 32'h0000_07F8));
    cmd_q.push_back(mk(usbfs_pkg::CMD_PMEM_WR, 11'h7F8, 4, 32'h1234_5678));
    cmd_q.push_back(mk(usbfs_pkg::CMD_PMEM_WR, 11'h7FD, 4, 32'hFFFF_FFFF));
    cmd_q.push_back(mk(usbfs_pkg::CMD_PMEM_WR, 11'h7FC, 4, 32'h03FF_FFFF));
    cmd_q.push_back(mk(usbfs_pkg::CMD_PMEM_RD, 11'h7FF, 1, 0));
    cmd_q.push_back(mk(usbfs_pkg::CMD_OUT, 11'h0, 1, 0));
    cmd_q.push_back(mk(usbfs_pkg::CMD_REG_WR, 11'h04C, 4, 32'h80));
    cmd_q.push_back(mk_xfer(usbfs_pkg::CMD_OUT, 0, 1));
    cmd_q.push_back(mk_xfer(usbfs_pkg::CMD_OUT, 1, 0));
    cmd_q.push_back(mk(usbfs_pkg::CMD_REG_WR, 11'h000, 4, 32'h0000_3030));
    cmd_q.push_back(mk_xfer(usbfs_pkg::CMD_IN, 0, 0));
    cmd_q.push_back(mk(usbfs_pkg::CMD_REG_WR, 11'h050, 4, 32'h0));
    cmd_q.push_back(mk(usbfs_pkg::CMD_REG_WR, 11'h01C, 2, 32'hFFFF_FFFF));
    cmd_q.push_back(mk(usbfs_pkg::CMD_REG_WR, 11'h000, 4, 32'h0));
    cmd_q.push_back(mk(usbfs_pkg::CMD_REG_WR, 11'h044, 2, 32'h0));
    cmd_q.push_back(mk(usbfs_pkg::CMD_BUS_RST, 0, 0, 0));
    cmd_q.push_back(mk(usbfs_pkg::CMD_RSVD, 11'h7FF, 7, 32'hFFFF_FFFF));
    cmd_q.push_back(mk(usbfs_pkg::CMD_REG_RD, 11'h044, 4, 0));
    n = 0;
    while (n < 900) begin
      if (n == 300) no_idle = 1'b1;
      if (n == 450) no_idle = 1'b0;
      if ($urandom_range(9) < 3) begin
        // well-formed: write a random value to an endpoint register, then run a transfer on it
        c = rand_item();
        c.endpoint = 3'($urandom_range(NEP - 1));
        cmd_q.push_back(mk(usbfs_pkg::CMD_REG_WR, 11'(c.endpoint * 4), 4,
                           {16'($urandom()), 2'($urandom()), 2'($urandom()), 12'($urandom())}));
        c.command = $urandom_range(1) ? usbfs_pkg::CMD_OUT : usbfs_pkg::CMD_IN;
        cmd_q.push_back(c);
        n += 2;
      end else begin
        cmd_q.push_back(rand_item());
        n++;
      end
      while (cmd_q.size() > 8) @(posedge clk);
    end
    while (cmd_q.size() > 0 || resp_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("usb_fs_device_endpoint_controller_core verification clean");
    end else begin
      $display("usb_fs_device_endpoint_controller_core verification failed");
    end
    $finish;
  end

  initial begin
    for (int i = 0; i < NEP; i++) ep_reg[i] = '0;
    for (int i = 0; i < 256; i++) gen_reg[i] = '0;
    for (int i = 0; i < PMEM; i++) pmem[i] = '0;
  end

endmodule
